>>> rtl/point_in_polygon_test_macros.svh
// assertion macros shared by the point-in-polygon checker
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pip_pkg.sv
// shared constants and types of the point-in-polygon block
package pip_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_WIDTH  = 16;
	localparam int CNT_W            = 7;
	localparam int IDX_IN_W         = 6;
	localparam int QUEUE_DEPTH      = 4;
	localparam int MIN_VERTICES     = 3;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// command kinds held in the queue
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_QUERY,
		OP_NONE
	} pip_op_t;

	typedef struct packed {
		logic    valid;
		pip_op_t op;
	} pip_head_t;

endpackage

>>> rtl/pip_ifs.sv
// valid/ready channel interfaces for requests and results
interface pip_in_if import pip_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [IDX_IN_W-1:0]           vertex_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;

	modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
	modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if import pip_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             inside_res;
	logic [CNT_W-1:0] crossing_count;

	modport source (output valid, inside_res, crossing_count, input ready);
	modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

>>> rtl/point_in_polygon_test.sv
// top level of the even-odd point-in-polygon tester
//
// channel   dir  payload                                    accepted when
// req       in   action, vertex_index, coord_x, coord_y     req.valid && req.ready
// rsp       out  inside_res, crossing_count                 rsp.valid && rsp.ready
// cfg       in   cfg_wdata (vertex_count)                   cfg_we
//
// a vertex write is taken by the back end while idle; a query over n >= 3 vertices runs
// through dispatch, n + 1 single-port reads, the crossing pipeline and the result load
// a query with fewer than three vertices is answered with zero crossings, without a walk
// reset clears only control state; the vertex table holds garbage until written
// the four-entry command queue keeps requests flowing while the walk or the
// result register is stalled
module point_in_polygon_test import pip_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	pip_in_if.sink           req,
	pip_out_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	// queue head seen by the back end
	pip_head_t                     head;
	logic [IW-1:0]                 head_idx;
	logic signed [COORD_WIDTH-1:0] head_x, head_y;
	logic                          pop;
	// vertex count clipped to the table size
	logic [CNT_W-1:0]              n_eff;

	// front: takes each transaction, sorts it into write / query / trivial query
	pip_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.head_idx  (head_idx),
		.head_x    (head_x),
		.head_y    (head_y),
		.pop       (pop),
		.n_eff     (n_eff)
	);

	// back: executes commands in order, walks the edges, drives rsp
	pip_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_idx (head_idx),
		.head_x   (head_x),
		.head_y   (head_y),
		.pop      (pop),
		.n_eff    (n_eff),
		.rsp      (rsp)
	);

endmodule

>>> rtl/pip_front.sv
// front end: config register, request classification and command queue
module pip_front import pip_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pip_in_if.sink                        req,
	input  logic                          cfg_we,
	input  logic [CNT_W-1:0]              cfg_wdata,
	output pip_head_t                     head,
	output logic [IW-1:0]                 head_idx,
	output logic signed [COORD_WIDTH-1:0] head_x,
	output logic signed [COORD_WIDTH-1:0] head_y,
	input  logic                          pop,
	output logic [CNT_W-1:0]              n_eff
);

	localparam int QW = $clog2(QUEUE_DEPTH);

	logic [CNT_W-1:0]              vertex_count_q;
	pip_op_t                       op_mem_q  [QUEUE_DEPTH];
	logic [IW-1:0]                 idx_mem_q [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0] x_mem_q   [QUEUE_DEPTH];
	logic signed [COORD_WIDTH-1:0] y_mem_q   [QUEUE_DEPTH];
	logic [QW-1:0]                 wr_ptr_q, rd_ptr_q;
	logic [QW:0]                   fill_q;

	pip_op_t op_in;
	logic    keep_in;
	logic    accept, push, do_pop;

	// saturate the vertex count at the table size
	assign n_eff = (int'(vertex_count_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
		: vertex_count_q;

	always_comb begin
		op_in   = OP_NONE;
		keep_in = 1'b1;
		if (req.action == ACT_WRITE) begin
			op_in   = OP_WRITE;
			keep_in = int'(req.vertex_index) < MAX_VERTICES;
		end else if (int'(n_eff) >= MIN_VERTICES) begin
			op_in = OP_QUERY;
		end
	end

	assign req.ready = (fill_q != (QW+1)'(QUEUE_DEPTH));
	assign accept    = req.valid && req.ready;
	assign push      = accept && keep_in;
	assign do_pop    = pop && head.valid;

	assign head.valid = (fill_q != '0);
	assign head.op    = op_mem_q[rd_ptr_q];
	assign head_idx   = idx_mem_q[rd_ptr_q];
	assign head_x     = x_mem_q[rd_ptr_q];
	assign head_y     = y_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			fill_q         <= '0;
		end else begin
			if (cfg_we) vertex_count_q <= cfg_wdata;
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (!push && do_pop) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_mem_q[wr_ptr_q]  <= op_in;
			idx_mem_q[wr_ptr_q] <= IW'(req.vertex_index);
			x_mem_q[wr_ptr_q]   <= req.coord_x;
			y_mem_q[wr_ptr_q]   <= req.coord_y;
		end
	end

endmodule

>>> rtl/pip_back.sv
// back end: vertex memory, edge walk sequencer, crossing pipeline and result register
module pip_back import pip_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pip_head_t                     head,
	input  logic [IW-1:0]                 head_idx,
	input  logic signed [COORD_WIDTH-1:0] head_x,
	input  logic signed [COORD_WIDTH-1:0] head_y,
	output logic                          pop,
	input  logic [CNT_W-1:0]              n_eff,
	pip_out_if.source                     rsp
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      rd_cnt_q, cnt_q;
	logic signed [CW-1:0]  px_q, py_q;
	logic                  rd_vld_q, rd_first_q, rd_last_q;
	logic                  out_vld_q, out_inside_q;
	logic [CNT_W-1:0]      out_cnt_q;

	logic [2*CW-1:0]       mem [MAX_VERTICES];
	logic signed [CW-1:0]  rd_x_q, rd_y_q, prev_x_q, prev_y_q;

	logic                  vld_s1, strad_s1, last_s1;
	logic signed [DW-1:0]  a_s1, b_s1, c_s1, d_s1;
	logic                  vld_s2, strad_s2, last_s2;
	logic signed [PW-1:0]  ab_s2, cd_s2;

	logic                  out_free, out_load, mem_we, mem_re, hit;
	logic [IW-1:0]         raddr;
	logic signed [DW-1:0]  xi_e, yi_e, xj_e, yj_e, px_e, py_e;
	logic                  neg, strad;

	assign out_free = !out_vld_q || rsp.ready;
	// result register takes a new value this cycle
	assign out_load = out_free && (((state_q == ST_IDLE) && head.valid && (head.op == OP_NONE))
		|| (state_q == ST_DONE));
	assign mem_we   = (state_q == ST_IDLE) && head.valid && (head.op == OP_WRITE);
	assign mem_re   = (state_q == ST_WALK);
	assign raddr    = (rd_cnt_q == n_eff) ? '0 : IW'(rd_cnt_q);

	always_comb begin
		pop = 1'b0;
		if (state_q == ST_IDLE && head.valid) begin
			unique case (head.op)
				OP_WRITE, OP_QUERY: pop = 1'b1;
				OP_NONE:            pop = out_free;
				default:            pop = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[head_idx] <= {head_x, head_y};
		if (mem_re) {rd_x_q, rd_y_q} <= mem[raddr];
	end

	// edge from the previous vertex (i) to the one just read (j)
	assign xi_e  = DW'(prev_x_q);
	assign yi_e  = DW'(prev_y_q);
	assign xj_e  = DW'(rd_x_q);
	assign yj_e  = DW'(rd_y_q);
	assign px_e  = DW'(px_q);
	assign py_e  = DW'(py_q);
	assign neg   = yj_e < yi_e;
	assign strad = (py_q > prev_y_q) != (py_q > rd_y_q);

	assign hit = vld_s2 && strad_s2 && (ab_s2 < cd_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= rd_vld_q && !rd_first_q;
			last_s1 <= rd_vld_q && rd_last_q;
			vld_s2  <= vld_s1;
			last_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			prev_x_q <= rd_x_q;
			prev_y_q <= rd_y_q;
		end
		strad_s1 <= strad;
		a_s1     <= px_e - xi_e;
		b_s1     <= neg ? (yi_e - yj_e) : (yj_e - yi_e);
		c_s1     <= xj_e - xi_e;
		d_s1     <= neg ? (yi_e - py_e) : (py_e - yi_e);
		strad_s2 <= strad_s1;
		ab_s2    <= PW'(a_s1) * PW'(b_s1);
		cd_s2    <= PW'(c_s1) * PW'(d_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_cnt_q     <= '0;
			cnt_q        <= '0;
			px_q         <= '0;
			py_q         <= '0;
			rd_vld_q     <= 1'b0;
			rd_first_q   <= 1'b0;
			rd_last_q    <= 1'b0;
			out_vld_q    <= 1'b0;
			out_inside_q <= 1'b0;
			out_cnt_q    <= '0;
		end else begin
			if (rsp.ready && !out_load) out_vld_q <= 1'b0;
			if (hit) cnt_q <= cnt_q + 1'b1;
			rd_vld_q <= mem_re;
			if (mem_re) begin
				rd_first_q <= (rd_cnt_q == '0);
				rd_last_q  <= (rd_cnt_q == n_eff);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid && head.op == OP_QUERY) begin
						px_q     <= head_x;
						py_q     <= head_y;
						cnt_q    <= '0;
						rd_cnt_q <= '0;
						state_q  <= ST_WALK;
					end else if (head.valid && head.op == OP_NONE && out_free) begin
						out_vld_q    <= 1'b1;
						out_inside_q <= 1'b0;
						out_cnt_q    <= '0;
					end
				end
				ST_WALK: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == n_eff) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (last_s2) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q    <= 1'b1;
						out_inside_q <= cnt_q[0];
						out_cnt_q    <= cnt_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.inside_res     = out_inside_q;
	assign rsp.crossing_count = out_cnt_q;

endmodule

>>> rtl/pip_checker.sv
// port-level checker for the point-in-polygon tester, bound to the top level
`include "point_in_polygon_test_macros.svh"

module pip_checker import pip_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_action,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_inside,
	input logic [CNT_W-1:0] rsp_count,
	input logic             cfg_we,
	input logic [CNT_W-1:0] cfg_wdata
);

	logic [7:0]       pend_q;
	logic [CNT_W-1:0] cfg_q;
	logic             q_in, r_out;

	assign q_in  = req_valid && req_ready && (req_action == ACT_QUERY);
	assign r_out = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cfg_q  <= '0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (q_in && !r_out) pend_q <= pend_q + 1'b1;
			else if (!q_in && r_out) pend_q <= pend_q - 1'b1;
		end
	end

	`PIP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inside) && $stable(rsp_count), "result changed while stalled")
	`PIP_ASSERT_IMP(a_parity, rsp_valid, rsp_inside == rsp_count[0], "inside flag disagrees with crossing count parity")
	`PIP_ASSERT_IMP(a_no_orphan, rsp_valid, pend_q != '0, "result without an outstanding query")
	`PIP_ASSERT_IMP(a_count_bound, rsp_valid, rsp_count <= cfg_q && (cfg_q >= CNT_W'(MIN_VERTICES) || rsp_count == '0), "crossing count exceeds edge count")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_inside (rsp.inside_res),
	.rsp_count  (rsp.crossing_count),
	.cfg_we     (cfg_we),
	.cfg_wdata  (cfg_wdata)
);

>>> bench/point_in_polygon_test_test.sv
// self-checking bench for the even-odd point-in-polygon block: directed table, then random polygons
module point_in_polygon_test_test;
	import pip_pkg::*;

	localparam int CW          = DEF_COORD_WIDTH;
	localparam int NV          = DEF_MAX_VERTICES;
	localparam int RANDOM_ITEMS = 1600;
	// longest query is 65 reads plus pipeline, plus a few queued writes
	localparam int SETTLE      = 100;
	localparam int LONG_HOLD   = 600;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t C_MIN = coord_t'(16'h8000);
	localparam coord_t C_MAX = coord_t'(16'h7FFF);

	// kinds of rows in the directed table
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_WRITE,
		ROW_QUERY
	} row_kind_t;

	// how widely random coordinates spread
	typedef enum logic [1:0] {
		SPAN_TINY,
		SPAN_MID,
		SPAN_FULL
	} span_t;

	typedef struct packed {
		logic             in_poly;
		logic [CNT_W-1:0] crossings;
	} answer_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] val;      // vertex count for a cfg row, slot for a write
		coord_t           x;
		coord_t           y;
		logic             typed;    // expected answer written in the row
		answer_t          ans;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	pip_in_if #(.COORD_WIDTH(CW)) req_if ();
	pip_out_if rsp_if ();

	point_in_polygon_test #(
		.MAX_VERTICES(NV),
		.COORD_WIDTH (CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// shadow copy of the vertex table and the count register
	coord_t           poly_x [NV];
	coord_t           poly_y [NV];
	logic [CNT_W-1:0] poly_count;

	// answers still owed by the block, oldest first
	answer_t pending_answers [$];

	int  mismatches;
	int  cycles;
	bit  hold_request;   // asks the receiver for one long hold-off
	bit  steady_sender;  // phase with no sender gaps

	// clock and the single reset at the start
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// even-odd crossing count, exact by cross multiplication at 64 bits
	function automatic answer_t predict_answer(input coord_t px, input coord_t py);
		answer_t     r;
		int          n;
		int          j;
		int unsigned hits;
		longint      a;
		longint      b;
		longint      c;
		longint      d;
		hits = 0;
		n = (poly_count > NV) ? NV : int'(poly_count);
		if (n >= MIN_VERTICES) begin
			for (int i = 0; i < n; i++) begin
				j = (i + 1 == n) ? 0 : i + 1;
				// the edge must straddle the ray; a vertex on py gets no extra count
				if ((py > poly_y[i]) != (py > poly_y[j])) begin
					a = longint'(px) - longint'(poly_x[i]);
					b = longint'(poly_y[j]) - longint'(poly_y[i]);
					c = longint'(poly_x[j]) - longint'(poly_x[i]);
					d = longint'(py) - longint'(poly_y[i]);
					if (b < 0) begin
						b = -b;
						d = -d;
					end
					// crossing x strictly right of px
					if (a * b < c * d)
						hits++;
				end
			end
		end
		r.in_poly   = hits[0];
		r.crossings = CNT_W'(hits);
		return r;
	endfunction

	function automatic coord_t rand_coord(input span_t span);
		int v;
		// extremes turn up in every span
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 1) ? C_MAX : C_MIN;
		case (span)
			SPAN_TINY: begin
				v = int'($urandom_range(0, 12)) - 6;
			end
			SPAN_MID: begin
				v = int'($urandom_range(0, 2000)) - 1000;
			end
			default: begin
				v = int'($urandom_range(0, 65535)) - 32768;
			end
		endcase
		return coord_t'(v);
	endfunction

	function automatic dir_row_t mk_row(input row_kind_t kind, input int val, input int x,
		input int y, input logic typed, input int ins, input int cnt);
		dir_row_t r;
		r.kind          = kind;
		r.val           = CNT_W'(val);
		r.x             = coord_t'(x);
		r.y             = coord_t'(y);
		r.typed         = typed;
		r.ans.in_poly   = ins[0];
		r.ans.crossings = CNT_W'(cnt);
		return r;
	endfunction

	// sender gap: mostly none or short, now and then long
	function automatic int pick_gap();
		int k;
		if (steady_sender)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// offer one transaction, hold it until taken, then update the shadow table or book its answer
	task automatic send_item(input logic act, input logic [IDX_IN_W-1:0] idx, input coord_t x,
		input coord_t y, input logic typed, input answer_t typed_ans);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid        <= 1'b1;
		req_if.action       <= act;
		req_if.vertex_index <= idx;
		req_if.coord_x      <= x;
		req_if.coord_y      <= y;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (act == ACT_WRITE) begin
			poly_x[idx] = x;
			poly_y[idx] = y;
		end else if (typed) begin
			pending_answers = {pending_answers, typed_ans};
		end else begin
			pending_answers = {pending_answers, predict_answer(x, y)};
		end
	endtask

	// stop offering, let every owed answer arrive, then let trailing writes settle
	task automatic wait_idle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		poly_count = value;
	endtask

	// new phase count: a fixed opening list of extremes, then mostly small polygons
	function automatic logic [CNT_W-1:0] pick_count(input int phase);
		int k;
		case (phase)
			0: return CNT_W'(127);
			1: return CNT_W'(NV);
			2: return CNT_W'(0);
			3: return CNT_W'(1);
			4: return CNT_W'(2);
			5: return CNT_W'(MIN_VERTICES);
			default: begin
				k = $urandom_range(0, 99);
				if (k < 70)
					return CNT_W'($urandom_range(3, 10));
				if (k < 85)
					return CNT_W'($urandom_range(11, 63));
				if (k < 95)
					return CNT_W'($urandom_range(0, 2));
				return CNT_W'($urandom_range(65, 127));
			end
		endcase
	endfunction

	// receiver: random stalls of mixed length, plus the long hold-off on request
	initial begin
		int   run_left;
		int   k;
		logic level;
		run_left = 0;
		level = 1'b0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				// block fills its queue and must stall the sender meanwhile
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_request = 1'b0;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					k = $urandom_range(0, 99);
					if (k < 10) begin
						level = 1'b1;
						run_left = $urandom_range(100, 300);
					end else if (k < 60) begin
						level = 1'b1;
						run_left = $urandom_range(1, 20);
					end else if (k < 92) begin
						level = 1'b0;
						run_left = $urandom_range(1, 3);
					end else begin
						level = 1'b0;
						run_left = $urandom_range(10, 80);
					end
				end
				rsp_if.ready <= level;
				run_left--;
			end
		end
	end

	// result checker: every accepted result against the oldest owed answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_answers.size() == 0) begin
				flag_mismatch("unexpected result, crossings", int'(rsp_if.crossing_count), -1);
			end else begin
				want = pending_answers.pop_front();
				if (rsp_if.inside_res !== want.in_poly)
					flag_mismatch("inside_res", int'(rsp_if.inside_res), int'(want.in_poly));
				if (rsp_if.crossing_count !== want.crossings)
					flag_mismatch("crossing_count", int'(rsp_if.crossing_count),
						int'(want.crossings));
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t         rows [$];
		dir_row_t         row;
		answer_t          no_ans;
		int               sent;
		int               phase;
		int               n;
		int               items;
		int               k;
		int               slot;
		span_t            span;
		coord_t           qx;
		coord_t           qy;
		logic [CNT_W-1:0] count_val;

		mismatches = 0;
		cycles = 0;
		hold_request = 1'b0;
		steady_sender = 1'b0;
		no_ans = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.action = ACT_WRITE;
		req_if.vertex_index = '0;
		req_if.coord_x = '0;
		req_if.coord_y = '0;
		poly_count = '0;
		for (int i = 0; i < NV; i++) begin
			poly_x[i] = '0;
			poly_y[i] = '0;
		end

		// directed table; typed answers are the ones plain from geometry
		rows = {rows, mk_row(ROW_QUERY, 0, 0, 0, 1'b1, 0, 0)};      // count 0 after reset
		rows = {rows, mk_row(ROW_WRITE, 0, -32768, -32768, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_WRITE, 1, 32767, -32768, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_WRITE, 2, 32767, 32767, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_WRITE, 3, -32768, 32767, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_CFG, 2, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 0, 0, 1'b1, 0, 0)};      // too few vertices
		rows = {rows, mk_row(ROW_CFG, 1, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 5, 5, 1'b1, 0, 0)};
		// full-range square
		rows = {rows, mk_row(ROW_CFG, 4, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 0, 0, 1'b1, 1, 1)};
		rows = {rows, mk_row(ROW_QUERY, 0, 32767, 0, 1'b1, 0, 0)};  // on the right edge
		rows = {rows, mk_row(ROW_QUERY, 0, -32768, 0, 1'b1, 1, 1)}; // on the left edge
		rows = {rows, mk_row(ROW_QUERY, 0, 0, -32768, 1'b1, 0, 0)}; // on the bottom y
		rows = {rows, mk_row(ROW_QUERY, 0, 0, 32767, 1'b1, 1, 1)};  // on the top y
		rows = {rows, mk_row(ROW_QUERY, 0, -32768, -32768, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 32767, 32767, 1'b0, 0, 0)};
		// triangle out of the first three corners
		rows = {rows, mk_row(ROW_CFG, 3, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, -32768, 32767, 1'b0, 0, 0)};
		// diamond whose side vertices sit on the query y
		rows = {rows, mk_row(ROW_WRITE, 0, 0, -4, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_WRITE, 1, 4, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_WRITE, 2, 0, 4, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_WRITE, 3, -4, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_CFG, 4, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, -10, 0, 1'b1, 0, 2)};    // ray through two vertices
		rows = {rows, mk_row(ROW_QUERY, 0, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 4, 0, 1'b0, 0, 0)};      // point on a vertex
		rows = {rows, mk_row(ROW_CFG, 0, 0, 0, 1'b0, 0, 0)};
		rows = {rows, mk_row(ROW_QUERY, 0, 1, 1, 1'b1, 0, 0)};

		wait (arst_n === 1'b1);

		foreach (rows[r]) begin
			row = rows[r];
			case (row.kind)
				ROW_CFG: begin
					wait_idle();
					write_count(row.val);
				end
				ROW_WRITE: begin
					send_item(ACT_WRITE, IDX_IN_W'(row.val), row.x, row.y, 1'b0, no_ans);
				end
				default: begin
					send_item(ACT_QUERY, '0, row.x, row.y, row.typed, row.ans);
				end
			endcase
		end

		// random phases: set a count, write a fresh polygon, then query it with
		// some stray vertex writes mixed in
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			count_val = pick_count(phase);
			write_count(count_val);
			n = (count_val > NV) ? NV : int'(count_val);
			k = $urandom_range(0, 9);
			span = (k < 4) ? SPAN_TINY : ((k < 7) ? SPAN_MID : SPAN_FULL);
			steady_sender = ($urandom_range(0, 3) == 0);

			// every slot in use is written before any query reads it
			for (int i = 0; i < n; i++) begin
				send_item(ACT_WRITE, IDX_IN_W'(i), rand_coord(span), rand_coord(span), 1'b0,
					no_ans);
				sent++;
			end

			// sender keeps offering while the receiver holds off
			if (phase == 0 || $urandom_range(0, 7) == 0)
				hold_request = 1'b1;

			items = $urandom_range(20, 60);
			for (int t = 0; t < items; t++) begin
				k = $urandom_range(0, 99);
				if (k < 20) begin
					// stray write anywhere in the table; may reshape the polygon
					send_item(ACT_WRITE, IDX_IN_W'($urandom_range(0, NV - 1)), rand_coord(span),
						rand_coord(span), 1'b0, no_ans);
				end else begin
					qx = rand_coord(span);
					qy = rand_coord(span);
					if (n > 0 && k < 45) begin
						// exactly on a stored vertex
						slot = $urandom_range(0, n - 1);
						qx = poly_x[slot];
						qy = poly_y[slot];
					end else if (n > 0 && k < 60) begin
						// level with a stored vertex
						slot = $urandom_range(0, n - 1);
						qy = poly_y[slot];
					end
					send_item(ACT_QUERY, IDX_IN_W'($urandom_range(0, NV - 1)), qx, qy, 1'b0,
						no_ans);
				end
				sent++;
			end
			phase++;
		end

		// drain and let the back end go quiet
		wait_idle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
